FILE: design/cart_pole_state_observer_unit_assert.svh
// assertion macros for the cart-pole state observer
`ifndef CART_POLE_STATE_OBSERVER_UNIT_ASSERT_SVH
`define CART_POLE_STATE_OBSERVER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked check, held off while reset is asserted
`define CPSO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// clocked check that also runs through reset
`define CPSO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPSO_ASSERT(lbl, clk, rstn, prop, msg)
`define CPSO_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/cpso_pkg.sv
// shared types and constants of the cart-pole state observer
package cpso_pkg;

    localparam int FIELD_W     = 32;
    localparam int GAIN_W      = 32;
    localparam int NUM_GAINS   = 8;
    localparam int GAIN_IDX_W  = 3;
    localparam int NUM_STATES  = 4;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DT_SCALED_DEF  = 655;

    // positions in the state vectors
    localparam int ST_ANGLE = 0;
    localparam int ST_RATE  = 1;
    localparam int ST_POS   = 2;
    localparam int ST_VEL   = 3;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_CORRECT = 2'd1,
        CMD_PREDICT = 2'd2
    } cmd_t;

endpackage

FILE: design/cpso_step.sv
// next-state logic of the observer: initialize, correct and predict
module cpso_step
    import cpso_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DT_SCALED  = DT_SCALED_DEF
) (
    input  cmd_t                         cmd,
    input  logic signed [FIELD_W-1:0]    angle,
    input  logic signed [FIELD_W-1:0]    angle_rate,
    input  logic signed [FIELD_W-1:0]    position,
    input  logic signed [FIELD_W-1:0]    velocity,
    input  logic signed [FIELD_W-1:0]    drive,
    input  logic signed [GAIN_W-1:0]     gain [NUM_GAINS],
    input  logic signed [DATA_WIDTH-1:0] pred [NUM_STATES],
    input  logic signed [DATA_WIDTH-1:0] corr [NUM_STATES],
    input  logic                         flag,
    output logic signed [DATA_WIDTH-1:0] pred_next [NUM_STATES],
    output logic signed [DATA_WIDTH-1:0] corr_next [NUM_STATES],
    output logic                         flag_next
);

    localparam int W  = DATA_WIDTH;
    localparam int MW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam int PW = MW + W;

    localparam logic signed [PW-1:0] PMax = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] PMin = ~PMax;
    // time step, clipped to the data range for narrow words
    localparam logic signed [MW-1:0] DtQ  = ((DT_SCALED >> (W-1)) != 0) ?
                                            MW'(PMax[W-1:0]) : MW'(DT_SCALED);

    function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
        if (v > PMax) begin
            return PMax[W-1:0];
        end else if (v < PMin) begin
            return PMin[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        return sat_w(PW'(a) + PW'(b));
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        return sat_w(PW'(a) - PW'(b));
    endfunction

    // exact product, floor shift by the fraction bits, then clip
    function automatic logic signed [W-1:0] mul_q(input logic signed [MW-1:0] a,
                                                  input logic signed [W-1:0]  b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return sat_w(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [W-1:0] fit(input logic signed [FIELD_W-1:0] x);
        return sat_w(PW'(x));
    endfunction

    logic signed [W-1:0] err_angle;
    logic signed [W-1:0] err_pos;

    always_comb begin
        pred_next = pred;
        corr_next = corr;
        flag_next = flag;
        err_angle = sat_sub(fit(angle), pred[ST_ANGLE]);
        err_pos   = sat_sub(fit(position), pred[ST_POS]);
        case (cmd)
            CMD_INIT: begin
                pred_next[ST_ANGLE] = fit(angle);
                pred_next[ST_RATE]  = fit(angle_rate);
                pred_next[ST_POS]   = fit(position);
                pred_next[ST_VEL]   = fit(velocity);
                corr_next[ST_ANGLE] = fit(angle);
                corr_next[ST_RATE]  = fit(angle_rate);
                corr_next[ST_POS]   = fit(position);
                corr_next[ST_VEL]   = fit(velocity);
                flag_next           = 1'b1;
            end
            CMD_CORRECT: begin
                for (int i = 0; i < NUM_STATES; i++) begin
                    corr_next[i] = sat_add(
                        sat_add(pred[i], mul_q(MW'(gain[2*i]), err_angle)),
                        mul_q(MW'(gain[2*i+1]), err_pos));
                end
                flag_next = 1'b0;
            end
            CMD_PREDICT: begin
                pred_next[ST_ANGLE] = sat_add(corr[ST_ANGLE], mul_q(DtQ, corr[ST_RATE]));
                pred_next[ST_RATE]  = sat_add(corr[ST_RATE], mul_q(DtQ, fit(drive)));
                pred_next[ST_POS]   = sat_add(corr[ST_POS], mul_q(DtQ, corr[ST_VEL]));
                pred_next[ST_VEL]   = corr[ST_VEL];
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: design/cart_pole_state_observer_unit.sv
// top level of the cart-pole state observer with stream ports and gain registers
//
// Fixed-gain four-state observer (angle, angle rate, cart position, cart
// velocity) in signed fixed point with saturating arithmetic. Each input
// transfer carries a command in s_tuser: initialize, correct with measured
// angle and position, or predict with a drive value; an unused command code
// leaves the state alone. Every transfer yields one result: both state
// vectors and the first-pass flag. An item is held in the input register,
// then a single pass of logic (innovation subtract, two multiplies, two
// saturating adds for a correct) updates the state registers, which also
// serve as the result register; the result is valid once the item is in
// them, and a new item is taken every cycle as long as m_tready stays high.
// Gains are written through the cfg port only while no item is in flight (the
// user must keep to this; the block does not enforce it); indexes 0..7 map to
// angle/rate/position/velocity, each first by angle error, then position error.
`include "cart_pole_state_observer_unit_assert.svh"

module cart_pole_state_observer_unit
    import cpso_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DT_SCALED  = DT_SCALED_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [GAIN_IDX_W-1:0]   cfg_index,
    input  logic [GAIN_W-1:0]       cfg_wdata,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    // angle, angle_rate, position, velocity, drive
    input  logic [5*FIELD_W-1:0]    s_tdata,
    // command
    input  logic [1:0]              s_tuser,

    output logic                    m_tvalid,
    input  logic                    m_tready,
    // pred_angle, pred_angle_rate, pred_position, pred_velocity,
    // corr_angle, corr_angle_rate, corr_position, corr_velocity
    output logic [8*FIELD_W-1:0]    m_tdata,
    // first_pass
    output logic [0:0]              m_tuser
);

    localparam int W  = DATA_WIDTH;
    localparam int MW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

    function automatic logic [FIELD_W-1:0] to_port(input logic signed [W-1:0] v);
        logic signed [MW-1:0] t;
        t = MW'(v);
        return t[FIELD_W-1:0];
    endfunction

    logic signed [GAIN_W-1:0]  gain_reg [NUM_GAINS];

    logic                      in_valid_reg;
    cmd_t                      cmd_reg;
    logic signed [FIELD_W-1:0] angle_reg;
    logic signed [FIELD_W-1:0] rate_reg;
    logic signed [FIELD_W-1:0] pos_reg;
    logic signed [FIELD_W-1:0] vel_reg;
    logic signed [FIELD_W-1:0] drive_reg;

    logic signed [W-1:0]       pred_reg  [NUM_STATES];
    logic signed [W-1:0]       corr_reg  [NUM_STATES];
    logic                      flag_reg;
    logic signed [W-1:0]       pred_next [NUM_STATES];
    logic signed [W-1:0]       corr_next [NUM_STATES];
    logic                      flag_next;
    logic                      out_valid_reg;

    logic                      advance;

    // the item moves into the state when the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_GAINS; i++) begin
                gain_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            gain_reg[cfg_index] <= signed'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= cmd_t'(s_tuser);
            angle_reg <= signed'(s_tdata[FIELD_W-1:0]);
            rate_reg  <= signed'(s_tdata[2*FIELD_W-1:FIELD_W]);
            pos_reg   <= signed'(s_tdata[3*FIELD_W-1:2*FIELD_W]);
            vel_reg   <= signed'(s_tdata[4*FIELD_W-1:3*FIELD_W]);
            drive_reg <= signed'(s_tdata[5*FIELD_W-1:4*FIELD_W]);
        end
    end

    cpso_step #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .DT_SCALED  (DT_SCALED)
    ) u_step (
        .cmd        (cmd_reg),
        .angle      (angle_reg),
        .angle_rate (rate_reg),
        .position   (pos_reg),
        .velocity   (vel_reg),
        .drive      (drive_reg),
        .gain       (gain_reg),
        .pred       (pred_reg),
        .corr       (corr_reg),
        .flag       (flag_reg),
        .pred_next  (pred_next),
        .corr_next  (corr_next),
        .flag_next  (flag_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STATES; i++) begin
                pred_reg[i] <= '0;
                corr_reg[i] <= '0;
            end
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                pred_reg <= pred_next;
                corr_reg <= corr_next;
                flag_reg <= flag_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = flag_reg;

    always_comb begin
        for (int i = 0; i < NUM_STATES; i++) begin
            m_tdata[i*FIELD_W +: FIELD_W]              = to_port(pred_reg[i]);
            m_tdata[(NUM_STATES+i)*FIELD_W +: FIELD_W] = to_port(corr_reg[i]);
        end
    end

    `CPSO_ASSERT(a_correct_clears_flag, aclk, aresetn, (advance && cmd_reg == CMD_CORRECT) |=> (!flag_reg && m_tvalid), "correct left first-pass flag set")
    `CPSO_ASSERT(a_init_loads_both, aclk, aresetn, (advance && cmd_reg == CMD_INIT) |=> (flag_reg && pred_reg[ST_ANGLE] == corr_reg[ST_ANGLE] && pred_reg[ST_VEL] == corr_reg[ST_VEL]), "initialize did not load both vectors")
    `CPSO_ASSERT(a_predict_keeps_corr, aclk, aresetn, (advance && cmd_reg == CMD_PREDICT) |=> ($stable(corr_reg[ST_POS]) && $stable(flag_reg) && pred_reg[ST_VEL] == corr_reg[ST_VEL]), "predict disturbed corrected state")
    `CPSO_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!m_tvalid && !in_valid_reg), "pipeline not empty after reset")

endmodule
